/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

/* hdl/csrf_pkg.sv */
package csrf_pkg;

    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_WORDS = 2'd1;

    localparam logic [15:0] RESET_NODES = 16'd256;
    localparam logic [6:0]  RESET_CHUNK = 7'd16;

    typedef struct packed {
        logic        last;
        logic [10:0] free_words;
        logic [11:0] used_words;
        logic [31:0] data_word;
        logic [1:0]  status;
    } t_result;

endpackage

/* hdl/csrf_out_q.sv */
module csrf_out_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  csrf_pkg::t_result  i_wr_data,
    output logic               o_valid,
    input  logic               i_ready,
    output csrf_pkg::t_result  o_data,
    output logic [1:0]         o_count
);
    import csrf_pkg::*;

    t_result    r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       deq;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_ent[r_rd_ptr];
    assign o_count = r_count;
    assign deq     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_wr;
        n_rd_ptr = r_rd_ptr ^ deq;
        n_count  = r_count + {1'b0, i_wr} - {1'b0, deq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ent[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* hdl/chunked_sample_ring_fifo.sv */
// Push, flush, query and rejected pop beats give one result beat, written to the output queue.
// A good pop of N words streams N beats at one per cycle while the output queue has room,
// through the registered sample memory read port; push beats are taken one per cycle while
// the queue is not full. A pop holds off new input until its last read is issued and queued.
// Synchronous active-low reset clears all counts, restores node count 256 and chunk size 16.
// Sample memory contents are not cleared by reset.
module chunked_sample_ring_fifo #(
    parameter int RING_DEPTH   = 2048,
    parameter int MAX_TRANSFER = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [31:0] sample, [38:32] word_count, [39] zero
    input  logic [csrf_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] command, [2] first_of_chunk
    input  logic [csrf_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] data_word, [43:32] used_words, [54:44] free_words, [55] zero
    output logic [csrf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // [1:0] status
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csrf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [csrf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import csrf_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CW    = AW + 1;
    localparam int CMP_W = (CW > 7) ? CW : 7;
    localparam logic [15:0] NODE_CLAMP = 16'(RING_DEPTH / 4);
    localparam logic [6:0]  MAX_LEN    = 7'(MAX_TRANSFER);

    function automatic logic [AW-1:0] slot_mask_of(input logic [15:0] nodes);
        logic [CW-1:0] raw;
        logic [AW-1:0] m;
        if (nodes > NODE_CLAMP) begin
            raw = CW'(RING_DEPTH);
        end else begin
            raw = {nodes[AW-2:0], 2'b00};
        end
        for (int j = 0; j < AW; j++) begin
            m[j] = raw > (CW'(1) << j);
        end
        return m;
    endfunction

    function automatic logic [AW-1:0] free_of(input logic [CW-1:0] used,
                                              input logic [AW-1:0] mask);
        logic [CW-1:0] cap;
        cap = {1'b0, mask};
        if (cap > used) begin
            return AW'(cap - used);
        end
        return '0;
    endfunction

    logic [31:0]   r_store [RING_DEPTH];
    logic [31:0]   r_rd_data;

    logic [6:0]    r_chunk,     n_chunk;
    logic [AW-1:0] r_slot_mask, n_slot_mask;
    logic [CW-1:0] r_wr_cnt,    n_wr_cnt;
    logic [CW-1:0] r_rd_cnt,    n_rd_cnt;
    logic [CW-1:0] r_pend_cnt,  n_pend_cnt;
    logic [6:0]    r_push_left, n_push_left;
    logic          r_push_open, n_push_open;
    logic [CW-1:0] r_pop_addr,  n_pop_addr;
    logic [6:0]    r_pop_left,  n_pop_left;
    logic          r_rd_pend,   n_rd_pend;
    logic          r_rd_last,   n_rd_last;

    logic [1:0]    cmd;
    logic          first;
    logic [31:0]   sample;
    logic [6:0]    word_count;
    logic          accept;
    logic          cfg_accept;
    logic          chunk_ok;
    logic [1:0]    len_st;
    logic [1:0]    st;
    logic [CW-1:0] used_cur;
    logic [AW-1:0] free_cur;
    logic [CW-1:0] used_nxt;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          rd_issue;
    logic [AW-1:0] rd_addr;
    logic          deq;
    logic          room;
    logic          q_wr;
    t_result       q_in;
    t_result       q_out;
    logic [1:0]    q_count;

    assign cmd        = i_s_tuser[1:0];
    assign first      = i_s_tuser[2];
    assign sample     = i_s_tdata[31:0];
    assign word_count = i_s_tdata[38:32];

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign o_s_tready  = (r_pop_left == 7'd0) && !r_rd_pend && (q_count != 2'd2);
    assign accept      = i_s_tvalid && o_s_tready;
    assign deq         = o_m_tvalid && i_m_tready;
    assign room        = ({1'b0, q_count} + {2'b00, r_rd_pend}) <= (3'd1 + {2'b00, deq});

    assign chunk_ok = (r_chunk != 7'd0) && ((r_chunk & (r_chunk - 7'd1)) == 7'd0);
    assign used_cur = r_wr_cnt - r_rd_cnt;
    assign free_cur = free_of(used_cur, r_slot_mask);
    assign rd_addr  = r_pop_addr[AW-1:0] & r_slot_mask;

    always_comb begin
        len_st = ST_OK;
        if (word_count == 7'd0) begin
            len_st = ST_BAD_LEN;
        end else if (word_count > MAX_LEN) begin
            len_st = ST_TOO_LONG;
        end else if (r_slot_mask == '0) begin
            len_st = ST_NO_SPACE;
        end else if (!chunk_ok) begin
            len_st = ST_BAD_LEN;
        end else if ((word_count & (r_chunk - 7'd1)) != 7'd0) begin
            len_st = ST_BAD_LEN;
        end
    end

    always_comb begin
        n_chunk     = r_chunk;
        n_slot_mask = r_slot_mask;
        n_wr_cnt    = r_wr_cnt;
        n_rd_cnt    = r_rd_cnt;
        n_pend_cnt  = r_pend_cnt;
        n_push_left = r_push_left;
        n_push_open = r_push_open;
        n_pop_addr  = r_pop_addr;
        n_pop_left  = r_pop_left;
        n_rd_last   = r_rd_last;
        mem_we      = 1'b0;
        mem_wa      = r_pend_cnt[AW-1:0] & r_slot_mask;
        rd_issue    = 1'b0;
        q_wr        = 1'b0;
        st          = ST_OK;
        q_in.data_word = '0;
        q_in.last      = 1'b1;

        if (r_rd_pend) begin
            q_wr           = 1'b1;
            q_in.data_word = r_rd_data;
            q_in.last      = r_rd_last;
        end else if (accept) begin
            q_wr = 1'b1;
            case (cmd)
                CMD_PUSH: begin
                    if (first) begin
                        n_push_open = 1'b0;
                        n_push_left = 7'd0;
                        st = len_st;
                        if (st == ST_OK && CMP_W'(word_count) > CMP_W'(free_cur)) begin
                            st = ST_NO_SPACE;
                        end
                        if (st == ST_OK) begin
                            mem_we      = 1'b1;
                            mem_wa      = r_wr_cnt[AW-1:0] & r_slot_mask;
                            n_pend_cnt  = r_wr_cnt + CW'(1);
                            n_push_left = word_count - 7'd1;
                            n_push_open = (word_count != 7'd1);
                            if (word_count == 7'd1) begin
                                n_wr_cnt = r_wr_cnt + CW'(1);
                            end
                        end
                    end else if (r_push_open) begin
                        mem_we      = 1'b1;
                        n_pend_cnt  = r_pend_cnt + CW'(1);
                        n_push_left = r_push_left - 7'd1;
                        if (r_push_left == 7'd1) begin
                            n_wr_cnt    = r_pend_cnt + CW'(1);
                            n_push_open = 1'b0;
                        end
                    end else begin
                        st = ST_BAD_LEN;
                    end
                end
                CMD_POP: begin
                    st = len_st;
                    if (st == ST_OK && CMP_W'(used_cur) < CMP_W'(word_count)) begin
                        st = ST_NO_SPACE;
                    end
                    if (st == ST_OK) begin
                        q_wr       = 1'b0;
                        n_rd_cnt   = r_rd_cnt + CW'(word_count);
                        n_pop_addr = r_rd_cnt;
                        n_pop_left = word_count;
                    end
                end
                CMD_FLUSH: begin
                    n_wr_cnt    = '0;
                    n_rd_cnt    = '0;
                    n_pend_cnt  = '0;
                    n_push_left = 7'd0;
                    n_push_open = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (r_pop_left != 7'd0 && room) begin
            rd_issue   = 1'b1;
            n_pop_addr = r_pop_addr + CW'(1);
            n_pop_left = r_pop_left - 7'd1;
            n_rd_last  = (r_pop_left == 7'd1);
        end
        n_rd_pend = rd_issue;

        if (cfg_accept) begin
            case (i_cfg_index)
                REG_NODE_COUNT: begin
                    n_slot_mask = slot_mask_of(i_cfg_data);
                    n_wr_cnt    = '0;
                    n_rd_cnt    = '0;
                    n_pend_cnt  = '0;
                    n_push_left = 7'd0;
                    n_push_open = 1'b0;
                end
                REG_CHUNK_WORDS: begin
                    n_chunk = i_cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end

        used_nxt        = n_wr_cnt - n_rd_cnt;
        q_in.status     = st;
        q_in.used_words = 12'(used_nxt);
        q_in.free_words = 11'(free_of(used_nxt, r_slot_mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= RESET_CHUNK;
            r_slot_mask <= slot_mask_of(RESET_NODES);
            r_wr_cnt    <= '0;
            r_rd_cnt    <= '0;
            r_pend_cnt  <= '0;
            r_push_left <= 7'd0;
            r_push_open <= 1'b0;
            r_pop_addr  <= '0;
            r_pop_left  <= 7'd0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
        end else begin
            r_chunk     <= n_chunk;
            r_slot_mask <= n_slot_mask;
            r_wr_cnt    <= n_wr_cnt;
            r_rd_cnt    <= n_rd_cnt;
            r_pend_cnt  <= n_pend_cnt;
            r_push_left <= n_push_left;
            r_push_open <= n_push_open;
            r_pop_addr  <= n_pop_addr;
            r_pop_left  <= n_pop_left;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= sample;
        end
        if (rd_issue) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    csrf_out_q u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_in),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (q_out),
        .o_count   (q_count)
    );

    assign o_m_tdata = {1'b0, q_out.free_words, q_out.used_words, q_out.data_word};
    assign o_m_tuser = q_out.status;
    assign o_m_tlast = q_out.last;

endmodule

/* hdl/csrf_checker.sv */
`include "assert_macros.svh"

module csrf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [csrf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic [1:0]                         o_m_tuser,
    input logic                               o_m_tlast
);
    import csrf_pkg::*;

    logic                  out_stall;
    logic                  err_beat;
    logic [OUT_DATA_W+2:0] out_beat;

    assign out_stall = o_m_tvalid && !i_m_tready;
    assign err_beat  = o_m_tvalid && (o_m_tuser != ST_OK);
    assign out_beat  = {o_m_tlast, o_m_tuser, o_m_tdata};

    // A stalled result beat keeps its contents.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(out_beat))

    // An error answer is always a single beat.
    `ASSERT_IMPLY(a_err_last, i_clk, i_rst_n, err_beat, o_m_tlast)

    // An error answer carries no sample.
    `ASSERT_IMPLY(a_err_no_data, i_clk, i_rst_n, err_beat, o_m_tdata[31:0] == 32'd0)

endmodule

bind chunked_sample_ring_fifo csrf_checker u_csrf_checker (.*);
